>>> rtl/stepping_clock_bus_capture_unit_assert.svh
// Assertion macros shared by the capture unit modules.
`ifndef STEPPING_CLOCK_BUS_CAPTURE_UNIT_ASSERT_SVH
`define STEPPING_CLOCK_BUS_CAPTURE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scbc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCBC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scbc assertion failed");

`endif

>>> rtl/scbc_pkg.sv
package scbc_pkg;

   localparam int SPEED_ENTRIES = 12;
   localparam logic [3:0] SPEED_MAX = 4'(SPEED_ENTRIES - 1);
   localparam logic [8:0] SPEED_LIMIT = 9'(SPEED_ENTRIES);

   localparam logic [3:0] ACT_TICK      = 4'd0;
   localparam logic [3:0] ACT_SAMPLE    = 4'd1;
   localparam logic [3:0] ACT_TOGGLE    = 4'd2;
   localparam logic [3:0] ACT_SET_MODE  = 4'd3;
   localparam logic [3:0] ACT_FASTER    = 4'd4;
   localparam logic [3:0] ACT_SLOWER    = 4'd5;
   localparam logic [3:0] ACT_SET_SPEED = 4'd6;
   localparam logic [3:0] ACT_PULSE     = 4'd7;
   localparam logic [3:0] ACT_CLEAR     = 4'd8;
   localparam logic [3:0] ACT_STATUS    = 4'd9;

   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_RECORD = 3'd1;
   localparam logic [2:0] KIND_ACK    = 3'd2;
   localparam logic [2:0] KIND_STATUS = 3'd3;
   localparam logic [2:0] KIND_NONE   = 3'd4;

   localparam logic [1:0] CODE_OK         = 2'd0;
   localparam logic [1:0] CODE_BAD_SPEED  = 2'd1;
   localparam logic [1:0] CODE_WRONG_MODE = 2'd2;

   localparam logic [9:0] ELAPSED_MAX = '1;

   typedef enum logic [3:0] {
      OP_TICK,
      OP_SAMPLE,
      OP_TOGGLE,
      OP_SET_MODE,
      OP_FASTER,
      OP_SLOWER,
      OP_SET_SPEED,
      OP_PULSE,
      OP_CLEAR,
      OP_STATUS,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  flags;
      logic        mode_valid;
      logic        mode_auto;
      logic        speed_ok;
      logic [3:0]  speed_arg;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_out_type;

   function automatic logic [9:0] period_of(input logic [3:0] idx);
      logic [9:0] p;
      unique case (idx)
         4'd0:    p = 10'd0;
         4'd1:    p = 10'd1000;
         4'd2:    p = 10'd500;
         4'd3:    p = 10'd250;
         4'd4:    p = 10'd100;
         4'd5:    p = 10'd50;
         4'd6:    p = 10'd33;
         4'd7:    p = 10'd25;
         4'd8:    p = 10'd20;
         4'd9:    p = 10'd15;
         4'd10:   p = 10'd12;
         default: p = 10'd10;
      endcase
      return p;
   endfunction

endpackage

>>> rtl/scbc_front.sv
module scbc_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [3:0]            req_action,
   input  logic [15:0]           req_bus_address,
   input  logic [7:0]            req_bus_data,
   input  logic [7:0]            req_bus_flags,
   input  logic [7:0]            req_argument,
   input  logic                  q_ready,
   output logic                  push,
   output scbc_pkg::entry_type   entry
);

   scbc_pkg::op_type op;

   always_comb begin
      unique case (req_action)
         scbc_pkg::ACT_TICK:      op = scbc_pkg::OP_TICK;
         scbc_pkg::ACT_SAMPLE:    op = scbc_pkg::OP_SAMPLE;
         scbc_pkg::ACT_TOGGLE:    op = scbc_pkg::OP_TOGGLE;
         scbc_pkg::ACT_SET_MODE:  op = scbc_pkg::OP_SET_MODE;
         scbc_pkg::ACT_FASTER:    op = scbc_pkg::OP_FASTER;
         scbc_pkg::ACT_SLOWER:    op = scbc_pkg::OP_SLOWER;
         scbc_pkg::ACT_SET_SPEED: op = scbc_pkg::OP_SET_SPEED;
         scbc_pkg::ACT_PULSE:     op = scbc_pkg::OP_PULSE;
         scbc_pkg::ACT_CLEAR:     op = scbc_pkg::OP_CLEAR;
         scbc_pkg::ACT_STATUS:    op = scbc_pkg::OP_STATUS;
         default:                 op = scbc_pkg::OP_NONE;
      endcase
   end

   // Arguments are checked here so that the back end only selects.
   always_comb begin
      entry.op         = op;
      entry.address    = req_bus_address;
      entry.data       = req_bus_data;
      entry.flags      = req_bus_flags;
      entry.mode_valid = (req_argument[7:1] == 7'd0);
      entry.mode_auto  = req_argument[0];
      entry.speed_ok   = ({1'b0, req_argument} < scbc_pkg::SPEED_LIMIT);
      entry.speed_arg  = req_argument[3:0];
   end

   assign req_ready = q_ready;
   assign push      = req_valid && q_ready;

endmodule

>>> rtl/scbc_queue.sv
`include "stepping_clock_bus_capture_unit_assert.svh"

module scbc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  scbc_pkg::entry_type     push_entry,
   output logic                    q_ready,
   input  logic                    pop,
   output scbc_pkg::queue_out_type q_out
);

   scbc_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign q_ready     = (count_ff != 2'd2);
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.entry = slot_ff[rd_ptr_ff];

   `SCBC_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= 2'd2)
   `SCBC_ASSERT_IMP(a_pop_nonempty, clock, reset, pop, count_ff != 2'd0)
   `SCBC_ASSERT_IMP(a_ptr_gap, clock, reset, count_ff == 2'd1, wr_ptr_ff != rd_ptr_ff)

endmodule

>>> rtl/scbc_back.sv
`include "stepping_clock_bus_capture_unit_assert.svh"

module scbc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  scbc_pkg::queue_out_type q_out,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_kind,
   output logic                    rsp_clock_level,
   output logic [1:0]              rsp_result_code,
   output logic                    rsp_mode_now,
   output logic [3:0]              rsp_speed_now,
   output logic [31:0]             rsp_cycle_count,
   output logic [15:0]             rsp_rec_address,
   output logic [7:0]              rsp_rec_data,
   output logic [7:0]              rsp_rec_flags
);

   logic        auto_ff, auto_in;
   logic [3:0]  speed_ff, speed_in;
   logic [9:0]  elapsed_ff, elapsed_in;
   logic [31:0] counter_ff, counter_in;
   logic [15:0] prev_addr_ff, prev_addr_in;
   logic [15:0] prev_df_ff, prev_df_in;
   logic        clk_out_ff, clk_out_in;

   logic        valid_ff;
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  code_ff, code_in;
   logic [31:0] count_ff, count_in;
   logic [15:0] rec_addr_ff, rec_addr_in;
   logic [7:0]  rec_data_ff, rec_data_in;
   logic [7:0]  rec_flags_ff, rec_flags_in;

   scbc_pkg::entry_type e;
   logic [9:0]  period;
   logic [9:0]  elapsed_inc;
   logic [15:0] sample_df;
   logic        reset_low;
   logic        sample_new;

   assign e           = q_out.entry;
   assign pop         = q_out.valid && (!valid_ff || rsp_ready);
   assign period      = scbc_pkg::period_of(speed_ff);
   assign elapsed_inc = (elapsed_ff == scbc_pkg::ELAPSED_MAX) ? elapsed_ff
                                                              : elapsed_ff + 10'd1;
   assign sample_df   = {e.flags, e.data};
   assign reset_low   = !e.flags[3];
   assign sample_new  = auto_ff && ((e.address != prev_addr_ff) || (sample_df != prev_df_ff));

   always_comb begin
      auto_in      = auto_ff;
      speed_in     = speed_ff;
      elapsed_in   = elapsed_ff;
      counter_in   = counter_ff;
      prev_addr_in = prev_addr_ff;
      prev_df_in   = prev_df_ff;
      clk_out_in   = clk_out_ff;
      kind_in      = scbc_pkg::KIND_ACK;
      code_in      = scbc_pkg::CODE_OK;
      rec_addr_in  = 16'd0;
      rec_data_in  = 8'd0;
      rec_flags_in = 8'd0;
      count_in     = 32'd0;
      unique case (e.op)
         scbc_pkg::OP_TICK: begin
            kind_in    = scbc_pkg::KIND_TICK;
            elapsed_in = elapsed_inc;
            if (auto_ff && (period != 10'd0)) begin
               if (elapsed_inc < (period >> 1)) begin
                  clk_out_in = 1'b1;
               end else if (elapsed_inc < period) begin
                  clk_out_in = 1'b0;
               end else begin
                  elapsed_in = 10'd0;
                  counter_in = counter_ff + 32'd1;
               end
            end
         end
         scbc_pkg::OP_SAMPLE: begin
            kind_in = scbc_pkg::KIND_NONE;
            if (sample_new) begin
               prev_addr_in = e.address;
               prev_df_in   = sample_df;
               if (reset_low) begin
                  counter_in = 32'd0;
               end
               if (!e.flags[7]) begin
                  kind_in      = scbc_pkg::KIND_RECORD;
                  rec_addr_in  = e.address;
                  rec_data_in  = e.data;
                  rec_flags_in = e.flags;
               end
            end
         end
         scbc_pkg::OP_TOGGLE: begin
            auto_in = !auto_ff;
            if (auto_ff) begin
               speed_in = 4'd0;
            end
         end
         scbc_pkg::OP_SET_MODE: begin
            if (e.mode_valid) begin
               auto_in = e.mode_auto;
               if (!e.mode_auto) begin
                  speed_in = 4'd0;
               end
            end
         end
         scbc_pkg::OP_FASTER: begin
            if (speed_ff < scbc_pkg::SPEED_MAX) begin
               speed_in = speed_ff + 4'd1;
            end
         end
         scbc_pkg::OP_SLOWER: begin
            if (speed_ff != 4'd0) begin
               speed_in = speed_ff - 4'd1;
            end
         end
         scbc_pkg::OP_SET_SPEED: begin
            if (e.speed_ok) begin
               speed_in = e.speed_arg;
            end else begin
               code_in = scbc_pkg::CODE_BAD_SPEED;
            end
         end
         scbc_pkg::OP_PULSE: begin
            if (auto_ff) begin
               code_in = scbc_pkg::CODE_WRONG_MODE;
            end else begin
               kind_in      = scbc_pkg::KIND_RECORD;
               clk_out_in   = 1'b1;
               counter_in   = reset_low ? 32'd0 : counter_ff + 32'd1;
               rec_addr_in  = e.address;
               rec_data_in  = e.data;
               rec_flags_in = e.flags;
            end
         end
         scbc_pkg::OP_CLEAR: begin
            counter_in = 32'd0;
         end
         scbc_pkg::OP_STATUS: begin
            kind_in      = scbc_pkg::KIND_STATUS;
            rec_addr_in  = e.address;
            rec_data_in  = e.data;
            rec_flags_in = e.flags;
         end
         default: begin
            kind_in = scbc_pkg::KIND_NONE;
         end
      endcase
      // A pulse record reports the counter as it stood before the step.
      if ((e.op == scbc_pkg::OP_PULSE) && !auto_ff) begin
         count_in = counter_ff;
      end else begin
         count_in = counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_ff      <= 1'b1;
         speed_ff     <= 4'd1;
         elapsed_ff   <= 10'd0;
         counter_ff   <= 32'd0;
         prev_addr_ff <= 16'hFFFF;
         prev_df_ff   <= 16'hFFFF;
         clk_out_ff   <= 1'b1;
         valid_ff     <= 1'b0;
      end else begin
         if (pop) begin
            auto_ff      <= auto_in;
            speed_ff     <= speed_in;
            elapsed_ff   <= elapsed_in;
            counter_ff   <= counter_in;
            prev_addr_ff <= prev_addr_in;
            prev_df_ff   <= prev_df_in;
            clk_out_ff   <= clk_out_in;
         end
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // The status fields of a result are the state just written, so they are
   // captured together with it.
   logic mode_out_ff;
   logic [3:0] speed_out_ff;
   logic clk_level_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff      <= kind_in;
         code_ff      <= code_in;
         count_ff     <= count_in;
         rec_addr_ff  <= rec_addr_in;
         rec_data_ff  <= rec_data_in;
         rec_flags_ff <= rec_flags_in;
         mode_out_ff  <= auto_in;
         speed_out_ff <= speed_in;
         clk_level_ff <= clk_out_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_clock_level = clk_level_ff;
   assign rsp_result_code = code_ff;
   assign rsp_mode_now    = mode_out_ff;
   assign rsp_speed_now   = speed_out_ff;
   assign rsp_cycle_count = count_ff;
   assign rsp_rec_address = rec_addr_ff;
   assign rsp_rec_data    = rec_data_ff;
   assign rsp_rec_flags   = rec_flags_ff;

   `SCBC_ASSERT_IMP(a_speed_range, clock, reset, 1'b1, speed_ff <= scbc_pkg::SPEED_MAX)
   `SCBC_ASSERT_NXT(a_pop_gives_rsp, clock, reset, pop, valid_ff)
   `SCBC_ASSERT_IMP(a_pop_room, clock, reset, pop, !valid_ff || rsp_ready)

endmodule

>>> rtl/stepping_clock_bus_capture_unit.sv
// Channel   | Direction | Handshake          | Payload
// req_      | in        | req_valid/ready    | action, bus_address, bus_data, bus_flags, argument
// rsp_      | out       | rsp_valid/ready    | kind, clock_level, result_code, mode_now,
//           |           |                    | speed_now, cycle_count, rec_address/data/flags
//
// Every item gives exactly one result; one item is taken per cycle when the result side
// keeps up; rsp_valid rises once the item has gone through a queue slot and the result
// register. The back end updates all state as it pops each item from the queue.
// A two-entry queue between the decoder and the back end, and the result register,
// let the request side keep transferring while a result waits to be taken.
// Reset is synchronous and active high; it empties the queue and restores the clock state.
module stepping_clock_bus_capture_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_bus_data,
   input  logic [7:0]  req_bus_flags,
   input  logic [7:0]  req_argument,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic        rsp_clock_level,
   output logic [1:0]  rsp_result_code,
   output logic        rsp_mode_now,
   output logic [3:0]  rsp_speed_now,
   output logic [31:0] rsp_cycle_count,
   output logic [15:0] rsp_rec_address,
   output logic [7:0]  rsp_rec_data,
   output logic [7:0]  rsp_rec_flags
);

   logic                    q_ready;
   logic                    push;
   logic                    pop;
   scbc_pkg::entry_type     entry;
   scbc_pkg::queue_out_type q_out;

   scbc_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_bus_address (req_bus_address),
      .req_bus_data    (req_bus_data),
      .req_bus_flags   (req_bus_flags),
      .req_argument    (req_argument),
      .q_ready         (q_ready),
      .push            (push),
      .entry           (entry)
   );

   scbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .q_ready    (q_ready),
      .pop        (pop),
      .q_out      (q_out)
   );

   scbc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_out           (q_out),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_clock_level (rsp_clock_level),
      .rsp_result_code (rsp_result_code),
      .rsp_mode_now    (rsp_mode_now),
      .rsp_speed_now   (rsp_speed_now),
      .rsp_cycle_count (rsp_cycle_count),
      .rsp_rec_address (rsp_rec_address),
      .rsp_rec_data    (rsp_rec_data),
      .rsp_rec_flags   (rsp_rec_flags)
   );

endmodule
